// File: src/sprr_pkg.sv
// ----------------------------------------------------------------------------
// sprr_pkg
// Shared types and constants of the strict priority egress queue.
// ----------------------------------------------------------------------------
`default_nettype none
package sprr_pkg;
  localparam int unsigned NumQueuesDefault  = 8;
  localparam int unsigned QueueDepthDefault = 64;
  localparam logic [31:0] MaxBytesReset     = 32'd1048576000;

  localparam logic CmdEnqueue = 1'b0;
  localparam logic CmdDequeue = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_OUT
  } sprr_state_t;

  typedef struct packed {
    logic start;
    logic finish;
  } sprr_cmd_t;

  typedef struct packed {
    logic busy;
  } sprr_status_t;
endpackage
`default_nettype wire

// File: src/sprr_in_if.sv
// ----------------------------------------------------------------------------
// sprr_in_if
// Input channel: one command word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface sprr_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [2:0]  queue_index;
  logic [15:0] packet_length;
  logic [15:0] packet_tag;
  logic [7:0]  paused_mask;
  modport source (output valid, cmd, queue_index, packet_length, packet_tag,
                  paused_mask, input ready);
  modport sink (input valid, cmd, queue_index, packet_length, packet_tag,
                paused_mask, output ready);
endinterface
`default_nettype wire

// File: src/sprr_out_if.sv
// ----------------------------------------------------------------------------
// sprr_out_if
// Output channel: one result word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface sprr_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic        dequeued_valid;
  logic [2:0]  served_queue;
  logic [15:0] out_length;
  logic [15:0] out_tag;
  logic [31:0] total_bytes;
  logic [31:0] queue_bytes;
  logic [2:0]  last_queue;
  modport source (output valid, accepted, dequeued_valid, served_queue, out_length,
                  out_tag, total_bytes, queue_bytes, last_queue, input ready);
  modport sink (input valid, accepted, dequeued_valid, served_queue, out_length,
                out_tag, total_bytes, queue_bytes, last_queue, output ready);
endinterface
`default_nettype wire

// File: src/sprr_ram.sv
// ----------------------------------------------------------------------------
// sprr_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module sprr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: src/sprr_ctrl.sv
// ----------------------------------------------------------------------------
// sprr_ctrl
// Controller: accept a word, wait in ST_READ for the memory, hold the result.
// ----------------------------------------------------------------------------
`default_nettype none
module sprr_ctrl
  import sprr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output sprr_cmd_t cmd
);
  sprr_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_READ;
      ST_READ: state_next = ST_OUT;
      ST_OUT: begin
        if (out_ready) state_next = in_valid ? ST_READ : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd.start  = 1'b0;
    cmd.finish = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_READ: cmd.finish = 1'b1;
      ST_OUT: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
        cmd.start = out_ready & in_valid;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// File: src/sprr_dp.sv
// ----------------------------------------------------------------------------
// sprr_dp
// Datapath: queue pointers, byte counts, arbitration and descriptor memory.
// ----------------------------------------------------------------------------
`default_nettype none
module sprr_dp
  import sprr_pkg::*;
#(
  parameter int unsigned NumQueues  = NumQueuesDefault,
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire sprr_cmd_t   cmd,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  sprr_in_if.sink          in_ch,
  sprr_out_if.source       out_ch
);
  localparam int unsigned QW = $clog2(NumQueues);
  localparam int unsigned SW = QW + 1;
  localparam int unsigned PW = $clog2(QueueDepth);
  localparam int unsigned CW = $clog2(QueueDepth + 1);
  localparam int unsigned AW = $clog2(NumQueues * QueueDepth);

  logic [31:0] max_bytes;
  logic [PW-1:0] head [NumQueues];
  logic [PW-1:0] tail [NumQueues];
  logic [CW-1:0] cnt  [NumQueues];
  logic [31:0]   qbytes [NumQueues];
  logic [31:0]   tbytes;
  logic [QW-1:0] rr_last;
  logic [2:0]    served_last;

  // captured word
  logic        c_cmd;
  logic [2:0]  c_qi;
  logic        c_ok;
  logic [QW-1:0] c_q;

  // decode at accept
  logic          qi_in;
  logic [QW-1:0] qi;
  logic          enq_ok;
  logic          found;
  logic [QW-1:0] sel;
  logic [NumQueues-1:0] elig;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   rdata;
  logic          we;

  assign qi_in  = 32'(in_ch.queue_index) < NumQueues;
  assign qi     = QW'(in_ch.queue_index);

  always_comb begin
    for (int q = 0; q < NumQueues; q++) begin
      elig[q] = (cnt[q] != '0) && !((q != 0) && (q < 8) && in_ch.paused_mask[q % 8]);
    end
  end

  always_comb begin
    logic [QW-1:0] c;
    logic [SW-1:0] s;
    found = 1'b0;
    sel   = '0;
    c     = '0;
    s     = '0;
    if (cnt[0] != '0) begin
      found = 1'b1;
    end else begin
      for (int i = NumQueues; i >= 1; i--) begin
        s = SW'(rr_last) + SW'(i);
        if (s >= SW'(NumQueues)) s = s - SW'(NumQueues);
        c = QW'(s);
        if (elig[c]) begin
          found = 1'b1;
          sel   = c;
        end
      end
    end
  end

  assign enq_ok = qi_in && (32'(cnt[qi]) < 32'(QueueDepth)) &&
                  ({1'b0, tbytes} + 33'(in_ch.packet_length) < {1'b0, max_bytes});
  assign we    = cmd.start && (in_ch.cmd == CmdEnqueue) && enq_ok;
  assign waddr = AW'(32'(qi) * QueueDepth + 32'(tail[qi]));
  assign raddr = AW'(32'(sel) * QueueDepth + 32'(head[sel]));

  sprr_ram #(.Width(32), .Depth(NumQueues * QueueDepth)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata ({in_ch.packet_length, in_ch.packet_tag}),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= MaxBytesReset;
    end else if (cfg_we) begin
      max_bytes <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < NumQueues; q++) begin
        head[q] <= '0;
        tail[q] <= '0;
        cnt[q] <= '0;
        qbytes[q] <= '0;
      end
      tbytes      <= '0;
      rr_last     <= '0;
      served_last <= '0;
      c_cmd       <= CmdEnqueue;
      c_ok        <= 1'b0;
      c_q         <= '0;
      c_qi        <= '0;
    end else begin
      if (cmd.start) begin
        c_cmd <= in_ch.cmd;
        c_qi  <= in_ch.queue_index;
        if (in_ch.cmd == CmdEnqueue) begin
          c_ok <= enq_ok;
          if (enq_ok) begin
            tail[qi]   <= (32'(tail[qi]) + 1 >= QueueDepth) ? '0 : tail[qi] + 1'b1;
            cnt[qi]    <= cnt[qi] + 1'b1;
            tbytes     <= tbytes + 32'(in_ch.packet_length);
            qbytes[qi] <= qbytes[qi] + 32'(in_ch.packet_length);
          end
        end else begin
          c_ok <= found;
          c_q  <= sel;
          if (found) begin
            head[sel] <= (32'(head[sel]) + 1 >= QueueDepth) ? '0 : head[sel] + 1'b1;
            cnt[sel]  <= cnt[sel] - 1'b1;
            if (sel != '0) rr_last <= sel;
            served_last <= 3'(sel);
          end
        end
      end
      if (cmd.finish && c_cmd == CmdDequeue && c_ok) begin
        tbytes      <= tbytes - 32'(rdata[31:16]);
        qbytes[c_q] <= qbytes[c_q] - 32'(rdata[31:16]);
      end
    end
  end

  // result register, loaded in the cycle after the memory read
  logic [31:0]   qb_now;

  always_comb begin
    qb_now = '0;
    if (32'(c_qi) < NumQueues) begin
      qb_now = qbytes[QW'(c_qi)];
      if (c_cmd == CmdDequeue && c_ok && c_q == QW'(c_qi)) begin
        qb_now = qbytes[QW'(c_qi)] - 32'(rdata[31:16]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_ch.accepted       <= (c_cmd == CmdEnqueue) && c_ok;
      out_ch.dequeued_valid <= (c_cmd == CmdDequeue) && c_ok;
      out_ch.served_queue   <= ((c_cmd == CmdDequeue) && c_ok) ? 3'(c_q) : 3'd0;
      out_ch.out_length     <= ((c_cmd == CmdDequeue) && c_ok) ? rdata[31:16] : 16'd0;
      out_ch.out_tag        <= ((c_cmd == CmdDequeue) && c_ok) ? rdata[15:0] : 16'd0;
      out_ch.total_bytes    <= ((c_cmd == CmdDequeue) && c_ok) ?
                               tbytes - 32'(rdata[31:16]) : tbytes;
      out_ch.queue_bytes    <= qb_now;
      out_ch.last_queue     <= served_last;
    end
  end
endmodule
`default_nettype wire

// File: src/strict_priority_rr_egress_queue.sv
// ----------------------------------------------------------------------------
// strict_priority_rr_egress_queue
// Egress port with strict priority on queue 0 and round robin on the rest.
// ----------------------------------------------------------------------------
//  channel | direction | word
//  in_ch   | sink      | cmd, queue_index, packet_length, packet_tag, paused_mask
//  out_ch  | source    | one result per input word
//  cfg     | write     | max_bytes
//
// Before its result is shown, each word updates the pointers and launches the
// descriptor memory read, then settles byte counts. A new word is taken in the
// cycle the pending result is taken, not before. rst clears all queues at once;
// a stalled result holds.
`default_nettype none
module strict_priority_rr_egress_queue
  import sprr_pkg::*;
#(
  parameter int unsigned NumQueues  = NumQueuesDefault,
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  sprr_in_if.sink          in_ch,
  sprr_out_if.source       out_ch
);
  sprr_cmd_t cmd;

  sprr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  sprr_dp #(.NumQueues(NumQueues), .QueueDepth(QueueDepth)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );
endmodule
`default_nettype wire

// File: tb/sv/sprr_tb_if.sv
// ----------------------------------------------------------------------------
// sprr_tb_if
// Result word type used by the egress queue checker.
// ----------------------------------------------------------------------------
package sprr_tb_pkg;
  typedef struct packed {
    logic        accepted;
    logic        dequeued_valid;
    logic [2:0]  served_queue;
    logic [15:0] out_length;
    logic [15:0] out_tag;
    logic [31:0] total_bytes;
    logic [31:0] queue_bytes;
    logic [2:0]  last_queue;
  } egress_result_t;
endpackage

// File: tb/sv/sprr_egress_checker.sv
// ----------------------------------------------------------------------------
// sprr_egress_checker
// Watches both channels and the register port, predicts each result word of
// the egress queue and compares it field by field with the block's output.
// ----------------------------------------------------------------------------
module sprr_egress_checker
  import sprr_pkg::*;
  import sprr_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  sprr_in_if.sink     in_mon,
  sprr_out_if.sink    out_mon,
  output int          fail_count,
  output int          pending_count
);
  localparam int NQ = NumQueuesDefault;
  localparam int QD = QueueDepthDefault;

  logic [31:0] desc_mem [NQ*QD];
  int unsigned head_ptr [NQ];
  int unsigned tail_ptr [NQ];
  int unsigned entries [NQ];
  logic [31:0] q_bytes [NQ];
  logic [31:0] sum_bytes;
  logic [2:0]  rr_last;
  logic [2:0]  served_q;
  logic [31:0] byte_limit;
  egress_result_t expected_words [$];

  assign pending_count = expected_words.size();

  function automatic egress_result_t schedule_word(logic c, logic [2:0] qi, logic [15:0] len,
                                                   logic [15:0] tag, logic [7:0] mask);
    egress_result_t r;
    bit found;
    int unsigned q, cq;
    logic [31:0] d;
    r = '0;
    found = 0;
    q = 0;
    if (c == CmdEnqueue) begin
      if (entries[qi] < QD && ({32'd0, sum_bytes} + len) < {32'd0, byte_limit}) begin
        desc_mem[qi*QD + tail_ptr[qi]] = {len, tag};
        tail_ptr[qi] = (tail_ptr[qi] + 1) % QD;
        entries[qi]++;
        sum_bytes += 32'(len);
        q_bytes[qi] += 32'(len);
        r.accepted = 1'b1;
      end
    end else begin
      if (entries[0] != 0) begin
        found = 1;
      end else begin
        for (int i = 1; i <= NQ; i++) begin
          cq = (i + rr_last) % NQ;
          if (!found && !(cq != 0 && mask[cq]) && entries[cq] != 0) begin
            found = 1;
            q = cq;
          end
        end
      end
      if (found) begin
        d = desc_mem[q*QD + head_ptr[q]];
        head_ptr[q] = (head_ptr[q] + 1) % QD;
        entries[q]--;
        sum_bytes -= 32'(d[31:16]);
        q_bytes[q] -= 32'(d[31:16]);
        if (q != 0) rr_last = 3'(q);
        served_q = 3'(q);
        r.dequeued_valid = 1'b1;
        r.served_queue = 3'(q);
        r.out_length = d[31:16];
        r.out_tag = d[15:0];
      end
    end
    r.total_bytes = sum_bytes;
    r.queue_bytes = q_bytes[qi];
    r.last_queue = served_q;
    return r;
  endfunction

  always @(posedge clk) begin
    egress_result_t e, a;
    if (rst) begin
      for (int q = 0; q < NQ; q++) begin
        head_ptr[q] = 0;
        tail_ptr[q] = 0;
        entries[q] = 0;
        q_bytes[q] = '0;
      end
      sum_bytes = '0;
      rr_last = '0;
      served_q = '0;
      byte_limit = MaxBytesReset;
      expected_words.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) byte_limit = cfg_wdata;
      if (out_mon.valid && out_mon.ready) begin
        a = '{out_mon.accepted, out_mon.dequeued_valid, out_mon.served_queue,
              out_mon.out_length, out_mon.out_tag, out_mon.total_bytes,
              out_mon.queue_bytes, out_mon.last_queue};
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          e = expected_words.pop_front();
          if (a.accepted !== e.accepted) begin
            $error("accepted exp %0d got %0d", e.accepted, a.accepted); fail_count++;
          end
          if (a.dequeued_valid !== e.dequeued_valid) begin
            $error("dequeued_valid exp %0d got %0d", e.dequeued_valid, a.dequeued_valid);
            fail_count++;
          end
          if (a.served_queue !== e.served_queue) begin
            $error("served_queue exp %0d got %0d", e.served_queue, a.served_queue);
            fail_count++;
          end
          if (a.out_length !== e.out_length) begin
            $error("out_length exp %0d got %0d", e.out_length, a.out_length); fail_count++;
          end
          if (a.out_tag !== e.out_tag) begin
            $error("out_tag exp %0d got %0d", e.out_tag, a.out_tag); fail_count++;
          end
          if (a.total_bytes !== e.total_bytes) begin
            $error("total_bytes exp %0d got %0d", e.total_bytes, a.total_bytes); fail_count++;
          end
          if (a.queue_bytes !== e.queue_bytes) begin
            $error("queue_bytes exp %0d got %0d", e.queue_bytes, a.queue_bytes); fail_count++;
          end
          if (a.last_queue !== e.last_queue) begin
            $error("last_queue exp %0d got %0d", e.last_queue, a.last_queue); fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_words = {expected_words, schedule_word(in_mon.cmd, in_mon.queue_index,
          in_mon.packet_length, in_mon.packet_tag, in_mon.paused_mask)};
    end
  end
endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives enqueue and dequeue words into the egress queue under random
// idling and stalls, walks the byte limit through several values, and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb;
  import sprr_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  int          fail_count;
  int          pending_count;
  bit          calm = 0;

  sprr_in_if  in_ch ();
  sprr_out_if out_ch ();

  strict_priority_rr_egress_queue dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  sprr_egress_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_mon(in_ch), .out_mon(out_ch),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_word(logic c, logic [2:0] qi, logic [15:0] len, logic [15:0] tag,
                           logic [7:0] mask);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= c;
    in_ch.queue_index <= qi;
    in_ch.packet_length <= len;
    in_ch.packet_tag <= tag;
    in_ch.paused_mask <= mask;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_limit(logic [31:0] v);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(int n, int len_max);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1))
        send_word(CmdEnqueue, 3'($urandom_range(0, 7)), 16'($urandom_range(0, len_max)),
                  16'($urandom), 8'($urandom));
      else
        send_word(CmdDequeue, 3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom),
                  $urandom_range(0, 3) == 0 ? 8'hff : 8'($urandom));
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = CmdEnqueue;
    in_ch.queue_index = '0;
    in_ch.packet_length = '0;
    in_ch.packet_tag = '0;
    in_ch.paused_mask = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_word(CmdDequeue, 3'd0, 16'hffff, 16'hffff, 8'h00);
    send_word(CmdEnqueue, 3'd0, 16'hffff, 16'hffff, 8'hff);
    send_word(CmdEnqueue, 3'd7, 16'd0, 16'h0000, 8'h00);
    send_word(CmdEnqueue, 3'd3, 16'd100, 16'h1234, 8'h00);
    send_word(CmdEnqueue, 3'd5, 16'd200, 16'habcd, 8'h00);
    send_word(CmdDequeue, 3'd0, 16'd0, 16'd0, 8'hff);
    send_word(CmdDequeue, 3'd7, 16'd0, 16'd0, 8'hff);
    send_word(CmdDequeue, 3'd3, 16'd0, 16'd0, 8'h00);
    send_word(CmdDequeue, 3'd5, 16'd0, 16'd0, 8'h00);
    send_word(CmdDequeue, 3'd7, 16'd0, 16'd0, 8'h00);
    send_word(CmdDequeue, 3'd0, 16'd0, 16'd0, 8'h00);
    for (int i = 0; i < 66; i++) send_word(CmdEnqueue, 3'd2, 16'(i), 16'(i), 8'h00);
    write_limit(32'd0);
    send_word(CmdEnqueue, 3'd1, 16'd0, 16'd1, 8'h00);
    send_word(CmdDequeue, 3'd2, 16'd0, 16'd0, 8'h04);
    send_word(CmdDequeue, 3'd2, 16'd0, 16'd0, 8'h00);
    write_limit(32'd3000);
    random_phase(150, 400);
    write_limit(32'hffffffff);
    random_phase(150, 65535);
    write_limit(32'd1);
    random_phase(40, 3);
    write_limit(MaxBytesReset);
    random_phase(150, 65535);
    calm = 1;
    random_phase(80, 65535);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule

// File: strict_priority_rr_egress_queue.f
src/sprr_pkg.sv
src/sprr_in_if.sv
src/sprr_out_if.sv
src/sprr_ram.sv
src/sprr_ctrl.sv
src/sprr_dp.sv
src/strict_priority_rr_egress_queue.sv
tb/sv/sprr_tb_if.sv
tb/sv/sprr_egress_checker.sv
tb/sv/tb.sv
